### hdl/vla_pkg.sv
// Shared types and constants for the voice list allocator.
// Used by vla_cell, voice_list_allocator and the bench; depends on nothing else.
package vla_pkg;

  // Event kinds carried on s_tuser
  localparam logic [1:0] KIND_TRIGGER = 2'd0;
  localparam logic [1:0] KIND_SWEEP   = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 16;
  localparam int LSC_W       = 9;
  localparam int MASK_W      = 8;
  localparam int POS_W       = 3;
  localparam int SAMPLE_IN_W = 8;
  localparam int COUNT_OUT_W = 4;
  localparam int READ_OUT_W  = 8;

  // Input beat layout
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_RETRIG   = 8;
  localparam int IN_MASK_LSB = 9;
  localparam int IN_POS_LSB  = 17;

  // Output beat layout
  localparam int OUT_STATUS    = 0;
  localparam int OUT_COUNT_LSB = 1;
  localparam int OUT_EVICTED   = 5;
  localparam int OUT_READ_LSB  = 6;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic mark_same;  // flag entries equal to the broadcast index
    logic mark_done;  // flag entries whose done bit is set
    logic step;       // close the first hole by one place
    logic load;       // write the broadcast index into the tail cell
  } cell_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SQUEEZE = 4'b0010,
    ST_APPEND  = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

endpackage

### hdl/vla_cell.sv
// One list position of the voice list: sample index plus a hole flag.
// Shifts left from its right neighbor while closing holes; uses vla_pkg.
module vla_cell #(
  parameter int IW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  vla_pkg::cell_cmd_t  cmd,
  input  logic [IW-1:0]       idx,
  input  logic                live,
  input  logic                tail,
  input  logic                done_bit,
  input  logic [IW-1:0]       right_sample,
  input  logic                right_hole,
  input  logic                shift_in,
  output logic                shift_out,
  output logic [IW-1:0]       sample,
  output logic                hole
);

  logic take_right;
  logic take_idx;

  // everything at or after the first hole moves one place left
  assign shift_out  = shift_in | hole;
  assign take_right = cmd.step & shift_out;
  assign take_idx   = cmd.load & tail;

  always_ff @(posedge clk) begin
    if (take_right) begin
      sample <= right_sample;
    end else if (take_idx) begin
      sample <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hole <= 1'b0;
    end else begin
      priority if (take_right) begin
        hole <= right_hole;
      end else if (take_idx) begin
        hole <= 1'b0;
      end else if (cmd.mark_same || cmd.mark_done) begin
        hole <= live & ((cmd.mark_same & (sample == idx)) | (cmd.mark_done & done_bit));
      end
    end
  end

endmodule

### hdl/voice_list_allocator.sv
// Voice list allocator top level: control sequencer, chain of vla_cell, output register.
// Depends on vla_pkg and vla_cell.
//
//  channel | signals                                   | beat
//  s_      | s_tvalid s_tready s_tdata[23:0] s_tuser   | one event
//  m_      | m_tvalid m_tready m_tdata[15:0]           | one result per event
//  cfg_    | cfg_valid cfg_ready cfg_data[8:0]         | loaded sample count
//
// Read, unused kind and rejected trigger: accept goes straight to the result state.
// Trigger: append; retrigger first squeezes out the removed voices, eviction squeezes out the oldest after the append.
// Sweep: squeeze out each finished voice; the hole-closing step of the
// cell chain removes one entry per cycle.
// rst is synchronous; list count and hole flags clear, entries are not cleared.
// A waiting result stalls the next event only in its DONE state.
module voice_list_allocator #(
  parameter int VOICE_LIMIT = 8,
  parameter int INDEX_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_index[7:0], retrigger[8], finished_mask[16:9], position[19:17], zero pad
  input  logic [vla_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [vla_pkg::KIND_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[0], active_count[4:1], evicted[5], read_index[13:6], zero pad
  output logic [vla_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vla_pkg::LSC_W-1:0]          cfg_data
);

  localparam int VL   = VOICE_LIMIT;
  localparam int IW   = INDEX_BITS;
  localparam int CNTW = $clog2(VL + 1);
  localparam int CMPW = (IW > vla_pkg::LSC_W) ? IW : vla_pkg::LSC_W;
  localparam int PCW  = (CNTW > vla_pkg::POS_W) ? CNTW : vla_pkg::POS_W;

  vla_pkg::state_t state, state_next;

  logic [vla_pkg::LSC_W-1:0] lsc;
  logic [CNTW-1:0]           count;

  logic [vla_pkg::KIND_W-1:0] kind_q;
  logic [IW-1:0]              idx_q;
  logic [vla_pkg::POS_W-1:0]  pos_q;
  logic                       err_q;
  logic                       ev_q;
  logic                       app_q;

  logic                       accept;
  logic [vla_pkg::KIND_W-1:0] in_kind;
  logic [IW-1:0]              in_idx;
  logic                       in_retrig;
  logic [vla_pkg::MASK_W-1:0] in_mask;
  logic                       in_range;

  vla_pkg::cell_cmd_t cmd;
  logic [IW-1:0]      cell_idx;
  logic [VL-1:0]      live_vec;
  logic [VL-1:0]      tail_vec;
  logic [VL-1:0]      done_vec;
  logic [VL-1:0]      hole_vec;
  logic [VL-1:0]      shift_vec;
  logic [IW-1:0]      sample_vec [VL];
  logic               any_hole;
  logic               evict_now;
  logic               out_free;

  logic [IW-1:0]      rd_val;

  logic                        st_q;
  logic [vla_pkg::COUNT_OUT_W-1:0] cnt_q;
  logic                        evo_q;
  logic [vla_pkg::READ_OUT_W-1:0]  rd_q;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == vla_pkg::ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  assign in_kind   = s_tuser;
  assign in_idx    = IW'(s_tdata[vla_pkg::IN_IDX_LSB +: vla_pkg::SAMPLE_IN_W]);
  assign in_retrig = s_tdata[vla_pkg::IN_RETRIG];
  assign in_mask   = s_tdata[vla_pkg::IN_MASK_LSB +: vla_pkg::MASK_W];
  assign in_range  = CMPW'(in_idx) < CMPW'(lsc);

  assign any_hole  = |hole_vec;
  assign evict_now = (count == CNTW'(VL - 1));
  assign cell_idx  = (state == vla_pkg::ST_IDLE) ? in_idx : idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsc <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lsc <= cfg_data;
    end
  end

  // Per-position flags for the chain
  always_comb begin
    for (int i = 0; i < VL; i++) begin
      live_vec[i] = CNTW'(i) < count;
      tail_vec[i] = CNTW'(i) == count;
      if (state == vla_pkg::ST_APPEND) begin
        done_vec[i] = (i == 0);
      end else if (i < vla_pkg::MASK_W) begin
        done_vec[i] = in_mask[i];
      end else begin
        done_vec[i] = 1'b0;
      end
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      vla_pkg::ST_IDLE: begin
        if (accept && in_kind == vla_pkg::KIND_TRIGGER && in_range && in_retrig) begin
          cmd.mark_same = 1'b1;
        end
        if (accept && in_kind == vla_pkg::KIND_SWEEP) begin
          cmd.mark_done = 1'b1;
        end
      end
      vla_pkg::ST_SQUEEZE: cmd.step = any_hole;
      vla_pkg::ST_APPEND: begin
        cmd.load      = 1'b1;
        cmd.mark_done = evict_now;
      end
      vla_pkg::ST_DONE: cmd = '0;
      default: cmd = '0;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < VL; g++) begin : g_cell
      logic [IW-1:0] r_sample;
      logic          r_hole;
      if (g < VL - 1) begin : g_mid
        assign r_sample = sample_vec[g+1];
        assign r_hole   = hole_vec[g+1];
      end else begin : g_end
        assign r_sample = sample_vec[g];
        assign r_hole   = 1'b0;
      end
      if (g == 0) begin : g_head
        assign shift_vec[g] = 1'b0;
      end
      if (g < VL - 1) begin : g_link
        vla_cell #(.IW(IW)) u_cell (
          .clk          (clk),
          .rst          (rst),
          .cmd          (cmd),
          .idx          (cell_idx),
          .live         (live_vec[g]),
          .tail         (tail_vec[g]),
          .done_bit     (done_vec[g]),
          .right_sample (r_sample),
          .right_hole   (r_hole),
          .shift_in     (shift_vec[g]),
          .shift_out    (shift_vec[g+1]),
          .sample       (sample_vec[g]),
          .hole         (hole_vec[g])
        );
      end else begin : g_last
        vla_cell #(.IW(IW)) u_cell (
          .clk          (clk),
          .rst          (rst),
          .cmd          (cmd),
          .idx          (cell_idx),
          .live         (live_vec[g]),
          .tail         (tail_vec[g]),
          .done_bit     (done_vec[g]),
          .right_sample (r_sample),
          .right_hole   (r_hole),
          .shift_in     (shift_vec[g]),
          .shift_out    (),
          .sample       (sample_vec[g]),
          .hole         (hole_vec[g])
        );
      end
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      vla_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == vla_pkg::KIND_TRIGGER && in_range) begin
            state_next = in_retrig ? vla_pkg::ST_SQUEEZE : vla_pkg::ST_APPEND;
          end else if (in_kind == vla_pkg::KIND_SWEEP) begin
            state_next = vla_pkg::ST_SQUEEZE;
          end else begin
            state_next = vla_pkg::ST_DONE;
          end
        end
      end
      vla_pkg::ST_SQUEEZE: begin
        if (!any_hole) begin
          state_next = (kind_q == vla_pkg::KIND_TRIGGER && !app_q) ?
                       vla_pkg::ST_APPEND : vla_pkg::ST_DONE;
        end
      end
      vla_pkg::ST_APPEND: state_next = evict_now ? vla_pkg::ST_SQUEEZE : vla_pkg::ST_DONE;
      vla_pkg::ST_DONE:   state_next = out_free ? vla_pkg::ST_IDLE : vla_pkg::ST_DONE;
      default:            state_next = vla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vla_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        count <= count - CNTW'(1);
      end else if (cmd.load) begin
        count <= count + CNTW'(1);
      end
    end
  end

  // Latch the event fields on accept; note append and eviction in ST_APPEND
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= in_kind;
      idx_q  <= in_idx;
      pos_q  <= s_tdata[vla_pkg::IN_POS_LSB +: vla_pkg::POS_W];
      err_q  <= (in_kind == vla_pkg::KIND_TRIGGER) & ~in_range;
      ev_q   <= 1'b0;
      app_q  <= 1'b0;
    end else if (state == vla_pkg::ST_APPEND) begin
      app_q <= 1'b1;
      if (evict_now) begin
        ev_q <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < VL; i++) begin
      if (PCW'(i) == PCW'(pos_q)) begin
        rd_val = sample_vec[i];
      end
    end
    if (kind_q != vla_pkg::KIND_READ || !(PCW'(pos_q) < PCW'(count))) begin
      rd_val = '0;
    end
  end

  // Output register; hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == vla_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vla_pkg::ST_DONE && out_free) begin
      st_q  <= err_q;
      cnt_q <= vla_pkg::COUNT_OUT_W'(count);
      evo_q <= ev_q;
      rd_q  <= vla_pkg::READ_OUT_W'(rd_val);
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[vla_pkg::OUT_STATUS]                                = st_q;
    m_tdata[vla_pkg::OUT_COUNT_LSB +: vla_pkg::COUNT_OUT_W]     = cnt_q;
    m_tdata[vla_pkg::OUT_EVICTED]                               = evo_q;
    m_tdata[vla_pkg::OUT_READ_LSB +: vla_pkg::READ_OUT_W]       = rd_q;
  end

  a_idle_room: assert property (@(posedge clk) disable iff (rst)
    (state == vla_pkg::ST_IDLE) |-> (count < CNTW'(VL)))
    else $error("list full while idle");

  a_holes_in_list: assert property (@(posedge clk) disable iff (rst)
    (hole_vec & ~live_vec) == '0)
    else $error("hole flagged beyond list end");

  a_idle_compact: assert property (@(posedge clk) disable iff (rst)
    (state == vla_pkg::ST_IDLE) |-> (hole_vec == '0))
    else $error("holes left after compaction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == vla_pkg::ST_APPEND && evict_now) |=> (count == CNTW'(VL) && hole_vec[0]))
    else $error("eviction did not mark the oldest voice");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for voice_list_allocator: event stream in, one status beat out per event.
// Keeps its own voice list in step with accepted beats; depends on vla_pkg and the RTL only.
module tb;

  localparam int VOICES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sample_index;
    logic       retrigger;
    logic [7:0] finished_mask;
    logic [2:0] position;
  } voice_event_t;

  typedef struct packed {
    logic       status;
    logic [3:0] active_count;
    logic       evicted;
    logic [7:0] read_index;
  } voice_report_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [vla_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [vla_pkg::KIND_W-1:0]     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [vla_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [vla_pkg::LSC_W-1:0]      cfg_data = '0;

  // mirror of the block's voice list and sample count
  logic [7:0]                voices [VOICES];
  logic [3:0]                list_len = '0;
  logic [vla_pkg::LSC_W-1:0] sample_limit = '0;

  voice_report_t pending_voice_reports [$];

  bit gaps_on = 1'b1;
  int cycles = 0;
  int mismatches = 0;
  int stall_left = 0;
  int n_triggers = 0, n_rejects = 0, n_evictions = 0;
  int n_sweeps = 0, n_reads = 0, n_unused = 0, n_settings = 0;

  voice_list_allocator #(.VOICE_LIMIT(VOICES), .INDEX_BITS(8)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_voice_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void drop_oldest();
    for (int i = 0; i + 1 < VOICES; i++) voices[i] = voices[i + 1];
    list_len--;
  endfunction

  // Advance the voice list by one event and return the status beat it should produce.
  function automatic voice_report_t apply_voice_event(input voice_event_t ev);
    voice_report_t r;
    int w;
    r = '0;
    w = 0;
    case (ev.kind)
      vla_pkg::KIND_TRIGGER: begin
        n_triggers++;
        if ({1'b0, ev.sample_index} >= sample_limit) begin
          r.status = 1'b1;
          n_rejects++;
        end else begin
          if (ev.retrigger) begin
            for (int i = 0; i < list_len; i++)
              if (voices[i] != ev.sample_index) begin
                voices[w] = voices[i];
                w++;
              end
            list_len = 4'(w);
          end
          while (list_len >= VOICES) begin
            drop_oldest();
            r.evicted = 1'b1;
          end
          voices[list_len] = ev.sample_index;
          list_len++;
          // steal the oldest voice so one slot stays free
          while (list_len >= VOICES) begin
            drop_oldest();
            r.evicted = 1'b1;
          end
          if (r.evicted) n_evictions++;
        end
      end
      vla_pkg::KIND_SWEEP: begin
        n_sweeps++;
        for (int i = 0; i < list_len; i++)
          if (!ev.finished_mask[i]) begin
            voices[w] = voices[i];
            w++;
          end
        list_len = 4'(w);
      end
      vla_pkg::KIND_READ: begin
        n_reads++;
        if (ev.position < list_len) r.read_index = voices[ev.position];
      end
      default: n_unused++;
    endcase
    r.active_count = list_len;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input voice_report_t want,
                                 input voice_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: want status %0d count %0d evicted %0d read %0d, got %0d %0d %0d %0d",
               $realtime, what, want.status, want.active_count, want.evicted, want.read_index,
               got.status, got.active_count, got.evicted, got.read_index);
  endtask

  // Result side: random stall bursts, compare every beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    voice_report_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status       = m_tdata[vla_pkg::OUT_STATUS];
        got.active_count = m_tdata[vla_pkg::OUT_COUNT_LSB +: vla_pkg::COUNT_OUT_W];
        got.evicted      = m_tdata[vla_pkg::OUT_EVICTED];
        got.read_index   = m_tdata[vla_pkg::OUT_READ_LSB +: vla_pkg::READ_OUT_W];
        if (pending_voice_reports.size() == 0) begin
          report_mismatch("unexpected beat", '0, got);
        end else begin
          want = pending_voice_reports[0];
          pending_voice_reports.delete(0);
          if (got.status !== want.status || got.active_count !== want.active_count ||
              got.evicted !== want.evicted || got.read_index !== want.read_index)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one event beat; s_tvalid stays high into the next call unless a gap is taken.
  task automatic send_event(input logic [1:0] kind, input logic [7:0] idx, input logic retrig,
                            input logic [7:0] mask, input logic [2:0] pos);
    voice_event_t ev;
    voice_report_t expected;
    ev = '{kind, idx, retrig, mask, pos};
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, pos, mask, retrig, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected = apply_voice_event(ev);
    pending_voice_reports = {pending_voice_reports, expected};
  endtask

  // Drop valid, wait for every outstanding result, then let the sequencer go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_voice_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_sample_count(input logic [vla_pkg::LSC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sample_limit = value;
    n_settings++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Empty list right after reset, sample count still zero.
  task automatic test_empty_list();
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd7);
    send_event(vla_pkg::KIND_SWEEP, 8'd0, 1'b0, 8'hFF, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd0, 1'b0, 8'h00, 3'd0);
    send_event(KIND_UNUSED, 8'hFF, 1'b1, 8'hFF, 3'd7);
    settle();
  endtask

  task automatic test_fill_and_steal();
    write_sample_count(9'd256);
    send_event(vla_pkg::KIND_TRIGGER, 8'd255, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd0, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd128, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd0, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd64, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd1, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd2, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd3, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd0, 1'b1, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd6);
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd7);
    settle();
  endtask

  task automatic test_sweep();
    send_event(vla_pkg::KIND_SWEEP, 8'd0, 1'b0, 8'h81, 3'd0);
    send_event(vla_pkg::KIND_SWEEP, 8'd0, 1'b0, 8'hF0, 3'd0);
    send_event(vla_pkg::KIND_READ, 8'd0, 1'b0, 8'h00, 3'd1);
    send_event(vla_pkg::KIND_SWEEP, 8'd0, 1'b0, 8'hFF, 3'd0);
    settle();
  endtask

  task automatic test_count_limits();
    write_sample_count(9'd1);
    send_event(vla_pkg::KIND_TRIGGER, 8'd1, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd0, 1'b1, 8'h00, 3'd0);
    settle();
    write_sample_count(9'd511);
    send_event(vla_pkg::KIND_TRIGGER, 8'd255, 1'b0, 8'h00, 3'd0);
    send_event(vla_pkg::KIND_TRIGGER, 8'd255, 1'b1, 8'h00, 3'd0);
    settle();
  endtask

  // Triggers most often, over a small pool of samples so retrigger and stealing hit often.
  task automatic test_random_events(input int n_items, input logic [vla_pkg::LSC_W-1:0] limit,
                                    input bit gaps);
    logic [7:0] idx, mask;
    int pick, edge_idx;
    settle();
    gaps_on = gaps;
    write_sample_count(limit);
    edge_idx = (limit > 9'd255) ? 255 : int'(limit);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: idx = 8'($urandom_range(0, 7));
        5, 6, 7:       idx = 8'($urandom_range(0, 255));
        default:       idx = 8'((edge_idx > 0 && $urandom_range(0, 1) != 0) ?
                                edge_idx - 1 : edge_idx);
      endcase
      case ($urandom_range(0, 3))
        0:       mask = 8'h01 << $urandom_range(0, 7);
        1:       mask = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
        2:       mask = 8'($urandom_range(0, 255));
        default: mask = 8'hFF << list_len;
      endcase
      if (pick < 48)
        send_event(vla_pkg::KIND_TRIGGER, idx, 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      else if (pick < 63)
        send_event(vla_pkg::KIND_SWEEP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   mask, 3'($urandom_range(0, 7)));
      else if (pick < 95)
        send_event(vla_pkg::KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      else
        send_event(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_fill_and_steal();
    test_sweep();
    test_count_limits();
    test_random_events(220, 9'd256, 1'b1);
    test_random_events(220, 9'd6, 1'b1);
    test_random_events(220, 9'd511, 1'b1);
    test_random_events(220, 9'($urandom_range(1, 256)), 1'b1);
    test_random_events(220, 9'd256, 1'b0);
    settle();
    if (pending_voice_reports.size() != 0) mismatches++;
    $display("covered %0d triggers (%0d refused, %0d stole a voice), %0d sweeps, %0d reads,",
             n_triggers, n_rejects, n_evictions, n_sweeps, n_reads);
    $display("%0d unused-kind events over %0d sample-count settings; %0d mismatches",
             n_unused, n_settings, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
